@@ rtl/tsc_pkg.sv @@
// Shared types and constants for the reference-page scale and offset calculator.
// Holds the power-of-two quotient table and the status struct passed between modules.
// No dependencies.
`default_nettype none

package tsc_pkg;

  // Divisor that turns nanoseconds into 100 ns units.
  localparam logic [6:0] DIVISOR = 7'd100;

  // One table entry: floor(2^k / 100) and 2^k mod 100.
  typedef struct packed {
    logic [56:0] quo;
    logic [6:0]  rem;
  } pow_entry_t;

  typedef pow_entry_t [63:0] pow_tbl_t;

  // Status that travels with the scale result.
  typedef struct packed {
    logic vld;  // a transfer is present in this stage
    logic ok;   // the parameter set is usable
  } scale_status_t;

  // Builds the table by doubling, so no division appears at all.
  function automatic pow_tbl_t build_pow_tbl();
    pow_tbl_t   tbl;
    logic [56:0] quo;
    logic [7:0]  rem;
    logic [7:0]  rem2;
    quo = '0;
    rem = 8'd1;
    for (int k = 0; k < 64; k++) begin
      tbl[6'(k)].quo = quo;
      tbl[6'(k)].rem = rem[6:0];
      rem2 = {rem[6:0], 1'b0};
      if (rem2 >= {1'b0, DIVISOR}) begin
        quo = {quo[55:0], 1'b1};
        rem = rem2 - {1'b0, DIVISOR};
      end else begin
        quo = {quo[55:0], 1'b0};
        rem = rem2;
      end
    end
    return tbl;
  endfunction

  localparam pow_tbl_t POW_TBL = build_pow_tbl();

endpackage

`default_nettype wire

@@ rtl/tsc_scale_calc.sv @@
// Six-stage pipeline that checks a clock-parameter set and computes
// floor(2^(32+shift) * multiplier / 100). Depends on tsc_pkg.
`default_nettype none

module tsc_scale_calc import tsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [7:0]          clock_flags,
  input  logic signed [5:0]   shift_amount,
  input  logic [31:0]         tick_multiplier,
  output scale_status_t       status,
  output logic [63:0]         scale
);

  localparam logic [31:0] RECIP_WIDE  = 32'h51EB851F;  // ceil(2^37 / 100)
  localparam logic [12:0] RECIP_SMALL = 13'd5243;      // ceil(2^19 / 100)
  localparam logic [5:0]  MIN_EXP     = 6'd7;

  logic [5:0]  exp_k;
  logic [31:0] hi_part;
  logic        set_ok;

  // Exponent k = 32 + shift is the shift field with its sign bit inverted.
  assign exp_k   = {~shift_amount[5], shift_amount[4:0]};
  // High word of multiplier * 2^k beyond bit 64; the scale fits when it is below 100.
  assign hi_part = tick_multiplier >> (7'd64 - {1'b0, exp_k});
  assign set_ok  = clock_flags[0] && (exp_k >= MIN_EXP) && (hi_part < {25'd0, DIVISOR});

  // Stage A
  logic        a_vld, a_ok;
  logic [31:0] a_mul;
  pow_entry_t  a_pow;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_vld;
    end
    a_ok  <= set_ok;
    a_mul <= tick_multiplier;
    a_pow <= POW_TBL[exp_k];
  end

  // Stage B: partial products of multiplier * quotient, and multiplier / 100.
  logic        b_vld, b_ok;
  logic [31:0] b_mul;
  logic [6:0]  b_rem;
  logic [63:0] b_plo;
  logic [31:0] b_phi;
  logic [63:0] b_recip;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_ok    <= a_ok;
    b_mul   <= a_mul;
    b_rem   <= a_pow.rem;
    b_plo   <= {32'd0, a_mul} * {32'd0, a_pow.quo[31:0]};
    b_phi   <= a_mul * {7'd0, a_pow.quo[56:32]};
    b_recip <= {32'd0, a_mul} * {32'd0, RECIP_WIDE};
  end

  // Stage C: split the multiplier as 100 * a + b and sum the partial products.
  logic [25:0] mul_quot;
  logic [31:0] mul_diff;

  assign mul_quot = b_recip[62:37];
  assign mul_diff = b_mul - ({6'd0, mul_quot} * 32'd100);

  logic        c_vld, c_ok;
  logic [25:0] c_a;
  logic [6:0]  c_b;
  logic [6:0]  c_rem;
  logic [63:0] c_pr;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_ok  <= b_ok;
    c_a   <= mul_quot;
    c_b   <= mul_diff[6:0];
    c_rem <= b_rem;
    c_pr  <= b_plo + {b_phi, 32'd0};
  end

  // Stage D: multiplier * (2^k mod 100) split into a * r and b * r.
  logic        d_vld, d_ok;
  logic [32:0] d_ar;
  logic [13:0] d_br;
  logic [63:0] d_pr;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
    end
    d_ok <= c_ok;
    d_ar <= {7'd0, c_a} * {26'd0, c_rem};
    d_br <= {7'd0, c_b} * {7'd0, c_rem};
    d_pr <= c_pr;
  end

  // Stage E: floor(b * r / 100) by reciprocal; exact for products below 10000.
  logic [26:0] br_recip;

  assign br_recip = {13'd0, d_br} * {14'd0, RECIP_SMALL};

  logic        e_vld, e_ok;
  logic [63:0] e_sum;
  logic [6:0]  e_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= d_vld;
    end
    e_ok   <= d_ok;
    e_sum  <= d_pr + {31'd0, d_ar};
    e_frac <= br_recip[25:19];
  end

  // Stage F
  always_ff @(posedge clk) begin
    if (rst) begin
      status.vld <= 1'b0;
    end else begin
      status.vld <= e_vld;
    end
    status.ok <= e_ok;
    scale     <= e_sum + {57'd0, e_frac};
  end

endmodule

`default_nettype wire

@@ rtl/tsc_div100.sv @@
// Eight-stage pipeline that divides a 64-bit value by 100, one 16-bit digit
// per pair of stages. No package dependencies.
`default_nettype none

module tsc_div100 (
  input  logic        clk,
  input  logic [63:0] x,
  output logic [63:0] quo
);

  localparam logic [23:0] RECIP = 24'd10737419;  // ceil(2^30 / 100)

  // Multiply stage of each digit step.
  logic [63:0] m_x    [0:3];
  logic [63:0] m_q    [0:3];
  logic [22:0] m_cur  [0:3];
  logic [46:0] m_prod [0:3];
  // Remainder stage of each digit step.
  logic [63:0] d_x    [0:3];
  logic [63:0] d_q    [0:3];
  logic [6:0]  d_rem  [0:3];

  logic [63:0] in_x   [0:3];
  logic [63:0] in_q   [0:3];
  logic [6:0]  in_rem [0:3];
  logic [22:0] cur    [0:3];
  logic [15:0] qdig   [0:3];
  logic [22:0] diff   [0:3];
  logic [63:0] q_ins  [0:3];

  always_comb begin
    in_x[0]   = x;
    in_q[0]   = '0;
    in_rem[0] = '0;
    for (int i = 1; i < 4; i++) begin
      in_x[i]   = d_x[i-1];
      in_q[i]   = d_q[i-1];
      in_rem[i] = d_rem[i-1];
    end
    for (int i = 0; i < 4; i++) begin
      // The running remainder is below 100, so the partial dividend stays under 2^23.
      cur[i]   = {in_rem[i], in_x[i][(3-i)*16 +: 16]};
      qdig[i]  = m_prod[i][45:30];
      diff[i]  = m_cur[i] - ({7'd0, qdig[i]} * 23'd100);
      q_ins[i] = m_q[i] | ({48'd0, qdig[i]} << ((3-i)*16));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      m_x[i]    <= in_x[i];
      m_q[i]    <= in_q[i];
      m_cur[i]  <= cur[i];
      m_prod[i] <= {24'd0, cur[i]} * {23'd0, RECIP};
      d_x[i]    <= m_x[i];
      d_q[i]    <= q_ins[i];
      d_rem[i]  <= diff[i][6:0];
    end
  end

  assign quo = d_q[3];

endmodule

`default_nettype wire

@@ rtl/tsc_mul_high.sv @@
// Three-stage pipeline giving the high 64 bits of a 64 x 64 unsigned product
// from four 32 x 32 partial products. No package dependencies.
`default_nettype none

module tsc_mul_high (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        out_vld,
  output logic [63:0] hi
);

  logic        p_vld;
  logic [63:0] ll, lh, hl, hh;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= in_vld;
    end
    ll <= {32'd0, a[31:0]}  * {32'd0, b[31:0]};
    lh <= {32'd0, a[31:0]}  * {32'd0, b[63:32]};
    hl <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
    hh <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
  end

  // The middle column collects the carries that reach the high word.
  logic        s_vld;
  logic [33:0] mid;
  logic [63:0] upper;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else begin
      s_vld <= p_vld;
    end
    mid   <= {2'd0, ll[63:32]} + {2'd0, lh[31:0]} + {2'd0, hl[31:0]};
    upper <= hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= s_vld;
    end
    hi <= upper + {62'd0, mid[33:32]};
  end

endmodule

`default_nettype wire

@@ rtl/tsc_page_scale_offset_calc_top.sv @@
// The block takes one clock-parameter set in every cycle (busy never rises) and
// returns its page scale and offset, marked by done for one cycle; the receiver
// cannot stall it. The path runs through the six-stage scale pipeline, the
// three-stage high-product multiplier and the output register. When
// params_valid is low, page_scale and page_offset are zero.
// Top level; depends on tsc_pkg, tsc_scale_calc, tsc_div100 and tsc_mul_high.
`default_nettype none

module tsc_page_scale_offset_calc_top import tsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         clock_flags,
  input  logic signed [5:0]  shift_amount,
  input  logic [31:0]        tick_multiplier,
  input  logic [63:0]        base_time_ns,
  input  logic [63:0]        base_ticks,
  output logic               done,
  output logic               params_valid,
  output logic [63:0]        page_scale,
  output logic [63:0]        page_offset
);

  localparam int LATENCY = 10;

  logic          accept;
  scale_status_t sc_status;
  logic [63:0]   sc_scale;
  logic [63:0]   time_quo;
  logic          mh_vld;
  logic [63:0]   mh_hi;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  tsc_scale_calc u_scale (
    .clk             (clk),
    .rst             (rst),
    .in_vld          (accept),
    .clock_flags     (clock_flags),
    .shift_amount    (shift_amount),
    .tick_multiplier (tick_multiplier),
    .status          (sc_status),
    .scale           (sc_scale)
  );

  tsc_div100 u_div (
    .clk (clk),
    .x   (base_time_ns),
    .quo (time_quo)
  );

  // The tick count waits in a delay line until its scale leaves the scale pipeline.
  logic [63:0] ticks_dly [0:5];

  always_ff @(posedge clk) begin
    ticks_dly[0] <= base_ticks;
    for (int i = 1; i < 6; i++) begin
      ticks_dly[i] <= ticks_dly[i-1];
    end
  end

  tsc_mul_high u_mul (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (sc_status.vld),
    .a       (ticks_dly[5]),
    .b       (sc_scale),
    .out_vld (mh_vld),
    .hi      (mh_hi)
  );

  // Scale and usability flag follow the multiplier; the divider's quotient arrives earlier and waits in quo_dly.
  logic [63:0] scale_dly [0:2];
  logic        ok_dly    [0:2];
  logic [63:0] quo_dly;

  always_ff @(posedge clk) begin
    scale_dly[0] <= sc_scale;
    ok_dly[0]    <= sc_status.ok;
    for (int i = 1; i < 3; i++) begin
      scale_dly[i] <= scale_dly[i-1];
      ok_dly[i]    <= ok_dly[i-1];
    end
    quo_dly <= time_quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mh_vld;
    end
    params_valid <= ok_dly[2];
    page_scale   <= ok_dly[2] ? scale_dly[2] : 64'd0;
    page_offset  <= ok_dly[2] ? (quo_dly - mh_hi) : 64'd0;
  end

  // An unusable set always reports zero scale and offset.
  assert property (@(posedge clk) disable iff (rst)
    done && !params_valid |-> (page_scale == 64'd0) && (page_offset == 64'd0))
    else $error("unusable set reported non-zero scale or offset");

  // Every transfer gives exactly one result.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result missing after an accepted transfer");

  assert property (@(posedge clk) disable iff (rst)
    !accept |-> ##LATENCY !done)
    else $error("result strobe without an accepted transfer");

  // A usable result needs the stable flag of the set it came from.
  assert property (@(posedge clk) disable iff (rst)
    done && params_valid |-> $past(clock_flags[0], LATENCY))
    else $error("usable result from a set without the stable flag");

endmodule

`default_nettype wire

@@ dv/tb_tsc_page_scale_offset_calc_top.sv @@
// Testbench for the reference-page scale and offset calculator: directed and random
// clock-parameter sets checked against an in-bench predictor.
// Depends on tsc_pkg and tsc_page_scale_offset_calc_top.
`timescale 1ns / 1ps

module tb_tsc_page_scale_offset_calc_top;
  import tsc_pkg::*;

  localparam int MIN_SHIFT     = -25;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct packed {
    logic        ok;
    logic [63:0] scale;
    logic [63:0] offset;
  } page_params_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [7:0]         clock_flags;
  logic signed [5:0]  shift_amount;
  logic [31:0]        tick_multiplier;
  logic [63:0]        base_time_ns;
  logic [63:0]        base_ticks;
  logic               done;
  logic               params_valid;
  logic [63:0]        page_scale;
  logic [63:0]        page_offset;

  page_params_t expected_pages[$];
  int           error_count;
  int           sent_count;
  int           usable_count;
  int           fallback_count;

  tsc_page_scale_offset_calc_top u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .clock_flags     (clock_flags),
    .shift_amount    (shift_amount),
    .tick_multiplier (tick_multiplier),
    .base_time_ns    (base_time_ns),
    .base_ticks      (base_ticks),
    .done            (done),
    .params_valid    (params_valid),
    .page_scale      (page_scale),
    .page_offset     (page_offset)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Multiplier bound at or above which the scale no longer fits in 64 bits.
  function automatic logic [63:0] scale_limit(logic signed [5:0] shift);
    int s;
    s = shift;
    return 64'(DIVISOR) << (32 - s);
  endfunction

  function automatic page_params_t predict_page_params(logic [7:0] flags,
                                                       logic signed [5:0] shift,
                                                       logic [31:0] mul,
                                                       logic [63:0] t_ns,
                                                       logic [63:0] ticks);
    page_params_t r;
    logic [127:0] num;
    logic [127:0] prod;
    int           s;
    r = '0;
    s = shift;
    if (!flags[0] || s < MIN_SHIFT) return r;
    if ({32'b0, mul} >= scale_limit(shift)) return r;
    num = {96'b0, mul} << (32 + s);
    num = num / 128'(DIVISOR);
    r.ok = 1'b1;
    r.scale = num[63:0];
    prod = {64'b0, ticks} * {64'b0, r.scale};
    r.offset = t_ns / 64'(DIVISOR) - prod[127:64];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Drives one parameter set and leaves start high after the transfer, so a
  // following set can go out back to back.
  task automatic send_params(logic [7:0] flags, logic signed [5:0] shift, logic [31:0] mul,
                             logic [63:0] t_ns, logic [63:0] ticks);
    @(negedge clk);
    start           = 1'b1;
    clock_flags     = flags;
    shift_amount    = shift;
    tick_multiplier = mul;
    base_time_ns    = t_ns;
    base_ticks      = ticks;
    do @(posedge clk); while (busy);
    expected_pages.push_back(predict_page_params(flags, shift, mul, t_ns, ticks));
    sent_count++;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] random_wide();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    page_params_t exp_page;
    if (!rst && done) begin
      if (expected_pages.size() == 0) begin
        report_mismatch("result strobe with no parameter set outstanding");
      end else begin
        exp_page = expected_pages.pop_front();
        if (exp_page.ok) usable_count++;
        else fallback_count++;
        if (params_valid !== exp_page.ok)
          report_mismatch($sformatf("params_valid %b, expected %b", params_valid, exp_page.ok));
        if (page_scale !== exp_page.scale)
          report_mismatch($sformatf("page_scale %h, expected %h", page_scale, exp_page.scale));
        if (page_offset !== exp_page.offset)
          report_mismatch($sformatf("page_offset %h, expected %h",
                                    page_offset, exp_page.offset));
      end
    end
  end

  task automatic test_stable_flag();
    send_params(8'hFE, 6'sd0, 32'hFFFF_FFFF, '1, '1);
    send_params(8'h00, 6'sd5, 32'd12345, 64'd1000, 64'd1);
    send_params(8'hFF, 6'sd0, 32'hFFFF_FFFF, '1, '1);
    send_params(8'h01, 6'sd3, 32'd0, 64'd99, '1);
    send_params(8'h01, 6'sd3, 32'd1, 64'd100, 64'd0);
    idle_cycles(2);
  endtask

  task automatic test_shift_range();
    send_params(8'h01, -6'sd32, 32'hFFFF_FFFF, '1, '1);
    send_params(8'h01, -6'sd26, 32'hFFFF_FFFF, '1, '1);
    send_params(8'h01, -6'sd25, 32'hFFFF_FFFF, '1, '1);
    send_params(8'h01, -6'sd25, 32'd1, 64'd12345, 64'd1);
    send_params(8'h01, 6'sd31, 32'd199, '1, '1);
    send_params(8'h01, 6'sd31, 32'd1, '0, '0);
    idle_cycles(3);
  endtask

  task automatic test_scale_overflow();
    logic [63:0] lim;
    lim = scale_limit(6'sd7);
    send_params(8'h01, 6'sd7, lim[31:0] - 32'd1, '1, '1);
    send_params(8'h01, 6'sd7, lim[31:0], '1, '1);
    send_params(8'h01, 6'sd31, 32'd200, '1, '1);
    send_params(8'h01, 6'sd31, 32'hFFFF_FFFF, '1, '1);
    lim = scale_limit(6'sd20);
    send_params(8'h01, 6'sd20, lim[31:0] - 32'd1, 64'd5, 64'h8000_0000_0000_0000);
    send_params(8'h01, 6'sd20, lim[31:0], 64'd5, 64'h8000_0000_0000_0000);
    idle_cycles(1);
  endtask

  // Where a large scale meets a small base time, the subtraction falls below zero.
  task automatic test_offset_wrap();
    send_params(8'h01, 6'sd31, 32'd199, 64'd0, '1);
    send_params(8'h01, 6'sd0, 32'hFFFF_FFFF, 64'd99, '1);
    send_params(8'h01, 6'sd10, 32'hDEAD_BEEF, 64'd0, 64'h5555_5555_5555_5555);
    send_params(8'h01, 6'sd0, 32'd0, '1, 64'hAAAA_AAAA_AAAA_AAAA);
    idle_cycles(4);
  endtask

  task automatic test_random_sets();
    logic [7:0]        flags;
    logic signed [5:0] shift;
    logic [31:0]       mul;
    logic [63:0]       lim;
    int                burst;
    int                remaining;
    bit                quiet;
    int                mode;
    remaining = RANDOM_ITEMS;
    while (remaining > 0) begin
      burst = $urandom_range(1, 40);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        flags = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) != 0) flags[0] = 1'b1;
        if ($urandom_range(0, 9) == 0) shift = 6'($urandom_range(0, 6) - 32);
        else shift = 6'($urandom_range(0, 56) - 25);
        lim = scale_limit(shift);
        mode = $urandom_range(0, 9);
        if (mode < 3 && lim <= 64'h1_0000_0001)
          mul = 32'(lim - 64'd1 + 64'($urandom_range(0, 2)));
        else if (mode == 3)
          mul = 32'($urandom_range(0, 255));
        else if (mode == 4)
          mul = 32'hFFFF_FFFF;
        else
          mul = $urandom;
        send_params(flags, shift, mul, random_wide(), random_wide());
        if (!quiet) idle_cycles(random_gap());
      end
      remaining -= burst;
    end
    idle_cycles(1);
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    clock_flags     = '0;
    shift_amount    = '0;
    tick_multiplier = '0;
    base_time_ns    = '0;
    base_ticks      = '0;
    error_count     = 0;
    sent_count      = 0;
    usable_count    = 0;
    fallback_count  = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_stable_flag();
    test_shift_range();
    test_scale_overflow();
    test_offset_wrap();
    test_random_sets();

    while (expected_pages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_pages.size() != 0) report_mismatch("results outstanding after drain");

    $display("Sent %0d parameter sets covering stable-flag, shift and overflow corners.",
             sent_count);
    $display("Checked %0d usable and %0d fallback results.", usable_count, fallback_count);
    if (error_count == 0) begin
      $display("tb_tsc_page_scale_offset_calc_top passed");
    end else begin
      $display("tb_tsc_page_scale_offset_calc_top failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", expected_pages.size());
    $display("tb_tsc_page_scale_offset_calc_top failed");
    $finish;
  end

endmodule

@@ tsc_page_scale_offset_calc_top.f @@
rtl/tsc_pkg.sv
rtl/tsc_scale_calc.sv
rtl/tsc_div100.sv
rtl/tsc_mul_high.sv
rtl/tsc_page_scale_offset_calc_top.sv
dv/tb_tsc_page_scale_offset_calc_top.sv
